// ===== rtl/rsts_pkg.sv =====
`timescale 1ns / 1ps
package rsts_pkg;

	// Input request: a start or an answer for the last probe.
	typedef struct packed {
		logic               op;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic               tile_matches;
	} in_item_t;

	// Result request: the next probe, or the end of the search.
	typedef struct packed {
		logic signed [15:0] probe_x;
		logic signed [15:0] probe_y;
		logic               search_over;
		logic               found;
	} out_item_t;

	// Input op codes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_ANSWER = 1'b1;

	// Datapath actions selected by the control word.
	typedef enum logic [3:0] {
		A_NONE,
		A_INIT,
		A_QZERO_DYINC,
		A_WRAP_DY,
		A_WRAP_DX,
		A_SQ_DX,
		A_SQ_DY,
		A_SQ_R,
		A_DY_INC,
		A_QUAD_INC,
		A_EMIT,
		A_FAIL
	} uc_act_t;

	// Branch conditions.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_RING_ZERO,
		C_QUAD_LT3,
		C_RING_GT_M,
		C_DX_GT_M,
		C_IN_RING
	} uc_cond_t;

	localparam int UC_PCW = 4;

	// Control store addresses.
	localparam logic [UC_PCW-1:0] UC_IDLE  = 4'd0;
	localparam logic [UC_PCW-1:0] UC_ADV0  = 4'd1;
	localparam logic [UC_PCW-1:0] UC_ADV1  = 4'd2;
	localparam logic [UC_PCW-1:0] UC_ADV2  = 4'd3;
	localparam logic [UC_PCW-1:0] UC_INIT  = 4'd4;
	localparam logic [UC_PCW-1:0] UC_SEEK  = 4'd5;
	localparam logic [UC_PCW-1:0] UC_SEEK2 = 4'd6;
	localparam logic [UC_PCW-1:0] UC_SQDX  = 4'd7;
	localparam logic [UC_PCW-1:0] UC_SQDY  = 4'd8;
	localparam logic [UC_PCW-1:0] UC_SQR   = 4'd9;
	localparam logic [UC_PCW-1:0] UC_TEST  = 4'd10;
	localparam logic [UC_PCW-1:0] UC_MISS  = 4'd11;
	localparam logic [UC_PCW-1:0] UC_QINC  = 4'd12;
	localparam logic [UC_PCW-1:0] UC_EMIT  = 4'd13;
	localparam logic [UC_PCW-1:0] UC_FAIL  = 4'd14;

	typedef struct packed {
		uc_act_t             act;
		uc_cond_t            cond;
		logic [UC_PCW-1:0]   target;
	} uc_word_t;

	// Status flags from the datapath for branching.
	typedef struct packed {
		logic ring_zero;
		logic quad_lt3;
		logic ring_gt_m;
		logic dx_gt_m;
		logic in_ring;
	} uc_stat_t;

	// Control store: the advance program, one word per step.
	// A word that does not branch falls through to the next address.
	function automatic uc_word_t uc_rom(input logic [UC_PCW-1:0] pc);
		uc_word_t w;
		w = '{act: A_NONE, cond: C_ALWAYS, target: UC_IDLE};
		unique case (pc)
			UC_IDLE:  w = '{act: A_NONE,        cond: C_NEVER,     target: UC_IDLE};
			UC_ADV0:  w = '{act: A_NONE,        cond: C_RING_ZERO, target: UC_INIT};
			UC_ADV1:  w = '{act: A_NONE,        cond: C_QUAD_LT3,  target: UC_QINC};
			UC_ADV2:  w = '{act: A_QZERO_DYINC, cond: C_ALWAYS,    target: UC_SEEK};
			UC_INIT:  w = '{act: A_INIT,        cond: C_NEVER,     target: UC_IDLE};
			UC_SEEK:  w = '{act: A_WRAP_DY,     cond: C_RING_GT_M, target: UC_FAIL};
			UC_SEEK2: w = '{act: A_WRAP_DX,     cond: C_DX_GT_M,   target: UC_SEEK};
			UC_SQDX:  w = '{act: A_SQ_DX,       cond: C_NEVER,     target: UC_IDLE};
			UC_SQDY:  w = '{act: A_SQ_DY,       cond: C_NEVER,     target: UC_IDLE};
			UC_SQR:   w = '{act: A_SQ_R,        cond: C_NEVER,     target: UC_IDLE};
			UC_TEST:  w = '{act: A_NONE,        cond: C_IN_RING,   target: UC_EMIT};
			UC_MISS:  w = '{act: A_DY_INC,      cond: C_ALWAYS,    target: UC_SEEK};
			UC_QINC:  w = '{act: A_QUAD_INC,    cond: C_RING_GT_M, target: UC_FAIL};
			UC_EMIT:  w = '{act: A_EMIT,        cond: C_ALWAYS,    target: UC_IDLE};
			UC_FAIL:  w = '{act: A_FAIL,        cond: C_ALWAYS,    target: UC_IDLE};
			default:  w = '{act: A_NONE,        cond: C_ALWAYS,    target: UC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/rsts_seq.sv =====
`timescale 1ns / 1ps
module rsts_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rsts_pkg::uc_stat_t stat,
	output rsts_pkg::uc_word_t ctrl,
	output logic              idle
);
	import rsts_pkg::*;

	logic [UC_PCW-1:0] pc_q;
	logic [UC_PCW-1:0] pc_next;
	logic              taken;

	// Fetch the control word of the current step.
	assign ctrl = uc_rom(pc_q);
	assign idle = (pc_q == UC_IDLE);

	// Evaluate the branch condition of the current word.
	always_comb begin
		case (ctrl.cond)
			C_NEVER:     taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_RING_ZERO: taken = stat.ring_zero;
			C_QUAD_LT3:  taken = stat.quad_lt3;
			C_RING_GT_M: taken = stat.ring_gt_m;
			C_DX_GT_M:   taken = stat.dx_gt_m;
			C_IN_RING:   taken = stat.in_ring;
			default:     taken = 1'b1;
		endcase
	end

	// Next step: wait in idle for an advance, then branch or fall through.
	always_comb begin
		if (pc_q == UC_IDLE) begin
			pc_next = start ? UC_ADV0 : UC_IDLE;
		end else if (taken) begin
			pc_next = ctrl.target;
		end else begin
			pc_next = pc_q + UC_PCW'(1);
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

`ifndef SYNTHESIS
	// An advance is only launched from the idle step.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (pc_q == UC_IDLE))
		else $error("advance launched while the program runs");
	// The program never reaches the unused address.
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q != 4'd15)
		else $error("step counter left the program");
`endif

endmodule

// ===== rtl/rsts_datapath.sv =====
`timescale 1ns / 1ps
module rsts_datapath #(
	parameter int RADIUS_LIMIT = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [7:0]         cfg_data,
	input  logic               in_accept,
	input  rsts_pkg::in_item_t in_data,
	input  logic               out_ready,
	output logic               out_valid,
	output rsts_pkg::out_item_t out_data,
	output logic               searching,
	input  rsts_pkg::uc_word_t ctrl,
	output rsts_pkg::uc_stat_t stat
);
	import rsts_pkg::*;

	// Ring and step counters hold up to one past the radius limit.
	localparam int RW = $clog2(RADIUS_LIMIT + 2);
	localparam int SW = 2 * RW + 1;
	localparam int CW = (RW > 8) ? RW : 8;

	logic [7:0]    radius_cap_q;
	logic          searching_q;
	logic          out_valid_q;
	out_item_t     out_q;
	logic [15:0]   centre_x_q;
	logic [15:0]   centre_y_q;
	logic [15:0]   last_x_q;
	logic [15:0]   last_y_q;
	logic [RW-1:0] ring_q;
	logic [RW-1:0] dx_q;
	logic [RW-1:0] dy_q;
	logic [1:0]    quad_q;
	logic [SW-1:0] acc_q;
	logic [SW-1:0] lo_q;

	logic [CW-1:0] mr_ext;
	logic [CW-1:0] lim_ext;
	logic [RW-1:0] eff_m;
	logic [RW-1:0] sq_in;
	logic [SW-1:0] sq;
	logic [SW-1:0] hi;
	logic [15:0]   dxe;
	logic [15:0]   dye;
	logic [15:0]   px;
	logic [15:0]   py;
	logic          go_start;
	logic          go_idle_ans;
	logic          go_match;
	logic          out_take;

	// Effective radius: the register saturated at the limit.
	assign mr_ext  = CW'(radius_cap_q);
	assign lim_ext = CW'(RADIUS_LIMIT);
	assign eff_m   = (mr_ext < lim_ext) ? RW'(mr_ext) : RW'(lim_ext);

	// Shared squarer; its operand comes from the active step.
	always_comb begin
		case (ctrl.act)
			A_SQ_DX: sq_in = dx_q;
			A_SQ_DY: sq_in = dy_q;
			default: sq_in = ring_q;
		endcase
	end
	assign sq = SW'(sq_in) * SW'(sq_in);
	assign hi = lo_q + (SW'(ring_q) << 1);

	// Status flags for the sequencer.
	assign stat.ring_zero = (ring_q == '0);
	assign stat.quad_lt3  = (quad_q != 2'd3);
	assign stat.ring_gt_m = (ring_q > eff_m);
	assign stat.dx_gt_m   = (dx_q > eff_m);
	assign stat.in_ring   = (acc_q >= lo_q) && (acc_q <= hi);

	// Probe tile in the current quadrant, wrapping modulo 2^16.
	assign dxe = 16'(dx_q);
	assign dye = 16'(dy_q);
	always_comb begin
		case (quad_q)
			2'd0: begin
				px = centre_x_q + dxe;
				py = centre_y_q + dye;
			end
			2'd1: begin
				px = centre_x_q - dxe;
				py = centre_y_q - dye;
			end
			2'd2: begin
				px = centre_x_q + dye;
				py = centre_y_q - dxe;
			end
			default: begin
				px = centre_x_q - dye;
				py = centre_y_q + dxe;
			end
		endcase
	end

	// Requests that finish in the cycle they are accepted.
	assign go_start    = in_accept && (in_data.op == OP_START);
	assign go_idle_ans = in_accept && (in_data.op == OP_ANSWER) && !searching_q;
	assign go_match    = in_accept && (in_data.op == OP_ANSWER) && searching_q &&
		in_data.tile_matches;
	assign out_take    = out_valid_q && out_ready;

	// Configuration register and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_cap_q <= 8'd0;
			searching_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radius_cap_q <= cfg_data;
			end
			if (go_start) begin
				searching_q <= 1'b1;
			end else if (go_match || (ctrl.act == A_FAIL)) begin
				searching_q <= 1'b0;
			end
			if (go_start || go_idle_ans || go_match ||
					(ctrl.act == A_EMIT) || (ctrl.act == A_FAIL)) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Search registers, stepped by the control word.
	always_ff @(posedge clk) begin
		if (go_start) begin
			centre_x_q <= in_data.start_x;
			centre_y_q <= in_data.start_y;
			last_x_q   <= in_data.start_x;
			last_y_q   <= in_data.start_y;
			ring_q     <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			quad_q     <= 2'd0;
		end else begin
			case (ctrl.act)
				A_INIT: begin
					ring_q <= RW'(1);
					dx_q   <= RW'(1);
					dy_q   <= '0;
					quad_q <= 2'd0;
				end
				A_QZERO_DYINC: begin
					quad_q <= 2'd0;
					dy_q   <= dy_q + RW'(1);
				end
				A_WRAP_DY: begin
					if (dy_q > eff_m) begin
						dy_q <= '0;
						dx_q <= dx_q + RW'(1);
					end
				end
				A_WRAP_DX: begin
					if (dx_q > eff_m) begin
						dx_q   <= RW'(1);
						dy_q   <= '0;
						ring_q <= ring_q + RW'(1);
					end
				end
				A_SQ_DX:    acc_q  <= sq;
				A_SQ_DY:    acc_q  <= acc_q + sq;
				A_SQ_R:     lo_q   <= sq;
				A_DY_INC:   dy_q   <= dy_q + RW'(1);
				A_QUAD_INC: quad_q <= quad_q + 2'd1;
				A_EMIT: begin
					last_x_q <= px;
					last_y_q <= py;
				end
				default: begin
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (go_start) begin
			out_q <= '{probe_x: in_data.start_x, probe_y: in_data.start_y,
				search_over: 1'b0, found: 1'b0};
		end else if (go_idle_ans || (ctrl.act == A_FAIL)) begin
			out_q <= '{probe_x: 16'sd0, probe_y: 16'sd0, search_over: 1'b1, found: 1'b0};
		end else if (go_match) begin
			out_q <= '{probe_x: last_x_q, probe_y: last_y_q, search_over: 1'b1,
				found: 1'b1};
		end else if (ctrl.act == A_EMIT) begin
			out_q <= '{probe_x: px, probe_y: py, search_over: 1'b0, found: 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign searching = searching_q;

`ifndef SYNTHESIS
	// The program only finishes into an empty result register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		((ctrl.act == A_EMIT) || (ctrl.act == A_FAIL)) |-> !out_valid_q)
		else $error("result written over a pending result");
	// A probe is emitted only for a ring inside the current radius.
	a_emit_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == A_EMIT) |-> ((ring_q != '0) && (ring_q <= eff_m) && (dx_q != '0)))
		else $error("probe emitted outside the rings");
	// A finished program always leaves a result behind.
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		((ctrl.act == A_EMIT) || (ctrl.act == A_FAIL)) |=> out_valid_q)
		else $error("finished program left no result");
`endif

endmodule

// ===== rtl/ring_spiral_tile_search_top.sv =====
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_data   (op, start_x, start_y, tile_matches)
// out      out_valid / out_ready out_data  (probe_x, probe_y, search_over, found)
// cfg      cfg_valid / cfg_ready cfg_data  (radius cap, 8 bits)
//
// A start, an answer while idle and a matching answer reach the result register in the next cycle.
// A miss runs the advance program: either a further quadrant of the same pair, or
// a ring scan over (dx, dy) pairs, each one tested through the shared squarer loop.
// Reset clears the step counter, the search flag, the result flag and the radius cap.
// A new request is taken while the program is idle and the result register is free
// or drains in the same cycle; a stalled result holds the input side.
module ring_spiral_tile_search_top #(
	parameter int RADIUS_LIMIT = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsts_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rsts_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);
	import rsts_pkg::*;

	uc_word_t ctrl;
	uc_stat_t stat;
	logic     idle;
	logic     searching;
	logic     in_accept;
	logic     start_adv;

	// Handshake: one request at a time, gated by a free result slot.
	assign in_ready  = idle && (!out_valid || out_ready);
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// A missed probe during a search launches the advance program.
	assign start_adv = in_accept && (in_data.op == OP_ANSWER) && searching &&
		!in_data.tile_matches;

	rsts_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_adv),
		.stat   (stat),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	rsts_datapath #(
		.RADIUS_LIMIT (RADIUS_LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_accept (in_accept),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.searching (searching),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule
